[rtl/bptc_pkg.sv]
// ----------------------------------------------------------------------------
// bptc_pkg
// shared types and constants of the barometric compensation pipeline
// ----------------------------------------------------------------------------
package bptc_pkg;

	localparam int DIV_STEP   = 2;
	localparam int DIV_WIDTH  = 64;
	localparam int DIV_STAGES = DIV_WIDTH / DIV_STEP;
	localparam int DVS_WIDTH  = 31;

	localparam logic signed [24:0] T_FINE_OFFSET = 25'sd128000;
	localparam logic [20:0]        ADC_P_BIAS    = 21'd1048576;
	localparam logic [11:0]        PRESS_SCALE   = 12'd3125;
	localparam logic [63:0]        VAR1_BIAS     = 64'h0000_8000_0000_0000;

	typedef enum logic [1:0] {
		REG_TEMP_CAL   = 2'd0,
		REG_PRESS_LOW  = 2'd1,
		REG_PRESS_HIGH = 2'd2,
		REG_PRESS_LAST = 2'd3
	} bptc_reg_t;

	typedef struct packed {
		logic [15:0] temp;
		logic        ok;
	} bptc_side_t;

endpackage

[rtl/bptc_div.sv]
// ----------------------------------------------------------------------------
// bptc_div
// pipelined signed 64 by 31 bit divider, truncating toward zero, wrapping
// ----------------------------------------------------------------------------
module bptc_div import bptc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [DIV_WIDTH-1:0]        num,
	input  logic signed [DVS_WIDTH-1:0] dvs,
	input  bptc_side_t                  side_in,
	output logic                        out_vld,
	output logic [DIV_WIDTH-1:0]        quo,
	output bptc_side_t                  side_out
);

	logic [DIV_STAGES:0]   vld_s;
	logic [DIV_WIDTH-1:0]  dvd_s  [0:DIV_STAGES];
	logic [DVS_WIDTH-1:0]  rem_s  [0:DIV_STAGES];
	logic [DVS_WIDTH-1:0]  mag_s  [0:DIV_STAGES];
	logic                  neg_s  [0:DIV_STAGES];
	bptc_side_t            side_s [0:DIV_STAGES];
	logic [DIV_WIDTH-1:0]  dvd_nx [0:DIV_STAGES-1];
	logic [DVS_WIDTH-1:0]  rem_nx [0:DIV_STAGES-1];
	logic                  vld_so;
	logic [DIV_WIDTH-1:0]  quo_so;
	bptc_side_t            side_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			vld_so <= 1'b0;
		end else if (en) begin
			vld_s  <= {vld_s[DIV_STAGES-1:0], in_vld};
			vld_so <= vld_s[DIV_STAGES];
		end
	end

	// magnitudes and quotient sign
	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s[0]  <= num[DIV_WIDTH-1] ? (DIV_WIDTH'(0) - num) : num;
			mag_s[0]  <= dvs[DVS_WIDTH-1] ? (DVS_WIDTH'(0) - dvs) : dvs;
			rem_s[0]  <= '0;
			neg_s[0]  <= num[DIV_WIDTH-1] ^ dvs[DVS_WIDTH-1];
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
		always_comb begin
			logic [DVS_WIDTH-1:0] r;
			logic [DIV_WIDTH-1:0] q;
			logic [DVS_WIDTH:0]   t;
			r = rem_s[k];
			q = dvd_s[k];
			for (int b = 0; b < DIV_STEP; b++) begin
				t = {r, q[DIV_WIDTH-1]};
				q = {q[DIV_WIDTH-2:0], 1'b0};
				if (t >= {1'b0, mag_s[k]}) begin
					t    = t - {1'b0, mag_s[k]};
					q[0] = 1'b1;
				end
				r = t[DVS_WIDTH-1:0];
			end
			rem_nx[k] = r;
			dvd_nx[k] = q;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k+1]  <= dvd_nx[k];
				rem_s[k+1]  <= rem_nx[k];
				mag_s[k+1]  <= mag_s[k];
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// restore sign
	always_ff @(posedge clk) begin
		if (en) begin
			quo_so  <= neg_s[DIV_STAGES] ? (DIV_WIDTH'(0) - dvd_s[DIV_STAGES])
			                             : dvd_s[DIV_STAGES];
			side_so <= side_s[DIV_STAGES];
		end
	end

	assign out_vld  = vld_so;
	assign quo      = quo_so;
	assign side_out = side_so;

endmodule

[rtl/baro_temp_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// integer temperature and pressure compensation of a barometric sensor
// ----------------------------------------------------------------------------
// One raw temperature/pressure pair enters per clock unless the output stalls,
// and its result passes 12 stages before the divide, 34 in the divider and 5
// after. The depth is set by the 64-bit pressure divide, which resolves two
// quotient bits per stage. Temperature comes out in signed hundredths of a
// degree, pressure in unsigned Q24.8 pascals; a zero divisor gives pressure 0
// with pressure_valid low. A stalled output freezes the whole pipeline. The
// user must write calibration through the cfg port only while no beat is in
// flight; the block itself does not enforce this.
module baro_temp_pressure_compensation import bptc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] temperature_centi,
	output logic [31:0]        pressure_q24_8,
	output logic               pressure_valid
);

	logic [47:0] tcal_q;
	logic [63:0] pcal_lo_q;
	logic [63:0] pcal_hi_q;
	logic [15:0] pcal_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q      <= '0;
			pcal_lo_q   <= '0;
			pcal_hi_q   <= '0;
			pcal_last_q <= '0;
		end else if (cfg_write) begin
			case (bptc_reg_t'(cfg_index))
				REG_TEMP_CAL:   tcal_q      <= cfg_data[47:0];
				REG_PRESS_LOW:  pcal_lo_q   <= cfg_data;
				REG_PRESS_HIGH: pcal_hi_q   <= cfg_data;
				REG_PRESS_LAST: pcal_last_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = tcal_q[15:0];
	assign t2 = tcal_q[31:16];
	assign t3 = tcal_q[47:32];
	assign p1 = pcal_lo_q[15:0];
	assign p2 = pcal_lo_q[31:16];
	assign p3 = pcal_lo_q[47:32];
	assign p4 = pcal_lo_q[63:48];
	assign p5 = pcal_hi_q[15:0];
	assign p6 = pcal_hi_q[31:16];
	assign p7 = pcal_hi_q[47:32];
	assign p8 = pcal_hi_q[63:48];
	assign p9 = pcal_last_q;

	logic       en;
	logic [11:0] vld_pre_s;
	logic [4:0]  vld_post_s;
	logic        div_vld;

	assign en       = !vld_post_s[4] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pre_s  <= '0;
			vld_post_s <= '0;
		end else if (en) begin
			vld_pre_s  <= {vld_pre_s[10:0], in_valid};
			vld_post_s <= {vld_post_s[3:0], div_vld};
		end
	end

	// fine temperature
	logic signed [17:0] a_s1;
	logic signed [16:0] d_s1;
	logic [20:0]        padc_s1, padc_s2, padc_s3, padc_s4, padc_s5, padc_s6;
	logic [20:0]        padc_s7, padc_s8, padc_s9;
	logic signed [33:0] m1_s2;
	logic [31:0]        dd_s2;
	logic signed [22:0] v1t_s3;
	logic signed [36:0] m2_s3;
	logic signed [23:0] tfine_s4;
	logic signed [33:0] m1;
	logic signed [33:0] dd;
	logic signed [36:0] m2;

	assign m1 = a_s1 * t2;
	assign dd = d_s1 * d_s1;
	assign m2 = $signed({1'b0, dd_s2[31:12]}) * t3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
			d_s1     <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
			padc_s1  <= ADC_P_BIAS - {1'b0, raw_pressure};
			m1_s2    <= m1;
			dd_s2    <= dd[31:0];
			padc_s2  <= padc_s1;
			v1t_s3   <= m1_s2[33:11];
			m2_s3    <= m2;
			padc_s3  <= padc_s2;
			tfine_s4 <= 24'(v1t_s3) + 24'($signed(m2_s3[36:14]));
			padc_s4  <= padc_s3;
		end
	end

	// centi-degrees with saturation
	logic signed [27:0] t5;
	logic signed [19:0] tc;
	logic [15:0]        tsat;

	assign t5 = 28'(tfine_s4) * 28'sd5 + 28'sd128;
	assign tc = t5[27:8];

	always_comb begin
		if (tc > 20'sd32767)
			tsat = 16'h7fff;
		else if (tc < -20'sd32768)
			tsat = 16'h8000;
		else
			tsat = tc[15:0];
	end

	logic [15:0]        temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11;
	logic [15:0]        temp_s12;
	logic signed [24:0] pv1_s5;
	logic [48:0]        sq_s6;
	logic signed [40:0] m5_s6, m2p_s6, m5_s7, m2p_s7;
	logic signed [49:0] sq;
	logic signed [41:0] a6l_s7, a3l_s7;
	logic signed [40:0] a6h_s7, a3h_s7;
	logic [63:0]        prod6_s8, x_s8, y_s8;
	logic signed [63:0] prod3_s8;
	logic [63:0]        v2_s9, v1b_s9;
	logic [63:0]        w_s10, nb_s10;
	logic [47:0]        wl_s11, wh;
	logic [31:0]        wh_s11;
	logic [43:0]        nl_s11, nh;
	logic [31:0]        nh_s11;
	logic [63:0]        wp;
	logic signed [30:0] dv_s12;
	logic [63:0]        num_s12;
	logic               ok_s12;

	assign sq = pv1_s5 * pv1_s5;
	assign wh = w_s10[63:32] * p1;
	assign nh = nb_s10[63:32] * PRESS_SCALE;
	assign wp = 64'(wl_s11) + {wh_s11, 32'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s5  <= tsat;
			pv1_s5   <= 25'(tfine_s4) - T_FINE_OFFSET;
			padc_s5  <= padc_s4;

			sq_s6    <= sq[48:0];
			m5_s6    <= pv1_s5 * p5;
			m2p_s6   <= pv1_s5 * p2;
			temp_s6  <= temp_s5;
			padc_s6  <= padc_s5;

			a6l_s7   <= $signed({1'b0, sq_s6[24:0]}) * p6;
			a6h_s7   <= $signed({1'b0, sq_s6[48:25]}) * p6;
			a3l_s7   <= $signed({1'b0, sq_s6[24:0]}) * p3;
			a3h_s7   <= $signed({1'b0, sq_s6[48:25]}) * p3;
			m5_s7    <= m5_s6;
			m2p_s7   <= m2p_s6;
			temp_s7  <= temp_s6;
			padc_s7  <= padc_s6;

			prod6_s8 <= 64'(a6l_s7) + (64'(a6h_s7) << 25);
			prod3_s8 <= 64'(a3l_s7) + (64'(a3h_s7) << 25);
			x_s8     <= (64'(m5_s7) << 17) + (64'(p4) << 35);
			y_s8     <= 64'(m2p_s7) << 12;
			temp_s8  <= temp_s7;
			padc_s8  <= padc_s7;

			v2_s9    <= prod6_s8 + x_s8;
			v1b_s9   <= 64'(prod3_s8 >>> 8) + y_s8;
			temp_s9  <= temp_s8;
			padc_s9  <= padc_s8;

			w_s10    <= v1b_s9 + VAR1_BIAS;
			nb_s10   <= {12'b0, padc_s9, 31'b0} - v2_s9;
			temp_s10 <= temp_s9;

			wl_s11   <= w_s10[31:0] * p1;
			wh_s11   <= wh[31:0];
			nl_s11   <= nb_s10[31:0] * PRESS_SCALE;
			nh_s11   <= nh[31:0];
			temp_s11 <= temp_s10;

			dv_s12   <= wp[63:33];
			ok_s12   <= (wp[63:33] != 31'd0);
			num_s12  <= 64'(nl_s11) + {nh_s11, 32'b0};
			temp_s12 <= temp_s11;
		end
	end

	logic [63:0] quo;
	bptc_side_t  side_div;

	bptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_pre_s[11]),
		.num      (num_s12),
		.dvs      (dv_s12),
		.side_in  ({temp_s12, ok_s12}),
		.out_vld  (div_vld),
		.quo      (quo),
		.side_out (side_div)
	);

	// pressure refinement
	logic signed [63:0] qsh;
	logic [63:0]        ll;
	logic [63:0]        lh, p8h;
	logic [63:0]        qs_s13, qs_s14, qs_s15, qs_s16;
	logic [63:0]        ll_s13, sq_s14;
	logic [31:0]        lh_s13, p8h_s13, h9_s15;
	logic signed [48:0] p8l_s13, l9_s15;
	logic signed [63:0] pr8, pr9;
	logic [63:0]        v2p_s14, v2p_s15, v2p_s16, v1p_s16;
	logic [63:0]        h9;
	bptc_side_t         side_s13, side_s14, side_s15, side_s16;
	logic [39:0]        psum;
	logic [15:0]        temp_s17;
	logic [31:0]        press_s17;
	logic               ok_s17;

	assign qsh  = $signed(quo) >>> 13;
	assign ll   = qsh[31:0] * qsh[31:0];
	assign lh   = qsh[31:0] * qsh[63:32];
	assign p8h  = quo[63:32] * {{16{p8[15]}}, p8};
	assign pr8  = 64'(p8l_s13) + $signed({p8h_s13, 32'b0});
	assign h9   = sq_s14[63:32] * {{16{p9[15]}}, p9};
	assign pr9  = 64'(l9_s15) + $signed({h9_s15, 32'b0});
	assign psum = qs_s16[39:0] + v1p_s16[39:0] + v2p_s16[39:0];

	always_ff @(posedge clk) begin
		if (en) begin
			qs_s13    <= quo;
			ll_s13    <= ll;
			lh_s13    <= lh[31:0];
			p8l_s13   <= $signed({1'b0, quo[31:0]}) * p8;
			p8h_s13   <= p8h[31:0];
			side_s13  <= side_div;

			sq_s14    <= ll_s13 + {lh_s13[30:0], 33'b0};
			v2p_s14   <= 64'(pr8 >>> 19);
			qs_s14    <= qs_s13;
			side_s14  <= side_s13;

			l9_s15    <= $signed({1'b0, sq_s14[31:0]}) * p9;
			h9_s15    <= h9[31:0];
			v2p_s15   <= v2p_s14;
			qs_s15    <= qs_s14;
			side_s15  <= side_s14;

			v1p_s16   <= 64'(pr9 >>> 25);
			v2p_s16   <= v2p_s15;
			qs_s16    <= qs_s15;
			side_s16  <= side_s15;

			temp_s17  <= side_s16.temp;
			ok_s17    <= side_s16.ok;
			press_s17 <= side_s16.ok ? (psum[39:8] + {{12{p7[15]}}, p7, 4'b0}) : 32'd0;
		end
	end

	assign out_valid         = vld_post_s[4];
	assign temperature_centi = temp_s17;
	assign pressure_q24_8    = press_s17;
	assign pressure_valid    = ok_s17;

endmodule

[test/baro_temp_pressure_compensation_checker.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_checker
// watches the calibration port and both channels, predicts each compensated
// result from its raw pair and compares it with the beat that leaves
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_checker import bptc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] temperature_centi,
	input  logic [31:0]        pressure_q24_8,
	input  logic               pressure_valid,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [15:0] temp;
		logic [31:0] press;
		logic        ok;
	} reading_t;

	logic [47:0] temp_cal;
	logic [63:0] press_lo;
	logic [63:0] press_hi;
	logic [15:0] press_last;
	reading_t    readings_due[$];

	assign pending = readings_due.size();

	function automatic logic [63:0] asr(logic [63:0] x, int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sx16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp);
		logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] adt, adp, v1, v2, d, tfine, tc, p, num, ma, md, q;
		reading_t r;
		t1 = {48'b0, temp_cal[15:0]};
		t2 = sx16(temp_cal[31:16]);
		t3 = sx16(temp_cal[47:32]);
		p1 = {48'b0, press_lo[15:0]};
		p2 = sx16(press_lo[31:16]);
		p3 = sx16(press_lo[47:32]);
		p4 = sx16(press_lo[63:48]);
		p5 = sx16(press_hi[15:0]);
		p6 = sx16(press_hi[31:16]);
		p7 = sx16(press_hi[47:32]);
		p8 = sx16(press_hi[63:48]);
		p9 = sx16(press_last);
		adt = {44'b0, rt};
		adp = {44'b0, rp};
		v1 = asr(((adt >> 3) - (t1 << 1)) * t2, 11);
		d = (adt >> 4) - t1;
		v2 = asr(asr(d * d, 12) * t3, 14);
		tfine = v1 + v2;
		tc = asr(tfine * 64'd5 + 64'd128, 8);
		if ($signed(tc) > 64'sd32767)
			r.temp = 16'h7fff;
		else if ($signed(tc) < -64'sd32768)
			r.temp = 16'h8000;
		else
			r.temp = tc[15:0];
		v1 = tfine - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = asr(((64'd1 << 47) + v1) * p1, 33);
		if (v1 == 64'd0) begin
			r.press = '0;
			r.ok = 1'b0;
		end else begin
			p = 64'd1048576 - adp;
			num = ((p << 31) - v2) * 64'd3125;
			ma = num[63] ? -num : num;
			md = v1[63] ? -v1 : v1;
			q = ma / md;
			p = (num[63] != v1[63]) ? -q : q;
			v1 = asr(p9 * asr(p, 13) * asr(p, 13), 25);
			v2 = asr(p8 * p, 19);
			p = asr(p + v1 + v2, 8) + (p7 << 4);
			r.press = p[31:0];
			r.ok = 1'b1;
		end
		return r;
	endfunction

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		reading_t e;
		if (!arst_n) begin
			temp_cal   <= '0;
			press_lo   <= '0;
			press_hi   <= '0;
			press_last <= '0;
		end else begin
			if (cfg_write) begin
				case (bptc_reg_t'(cfg_index))
					REG_TEMP_CAL:   temp_cal   <= cfg_data[47:0];
					REG_PRESS_LOW:  press_lo   <= cfg_data;
					REG_PRESS_HIGH: press_hi   <= cfg_data;
					REG_PRESS_LAST: press_last <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				readings_due.push_back(compensate(raw_temperature, raw_pressure));
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					e = readings_due.pop_front();
					if (temperature_centi !== e.temp)
						report($sformatf("temperature %0d, expected %0d",
							temperature_centi, $signed(e.temp)));
					if (pressure_q24_8 !== e.press)
						report($sformatf("pressure %h, expected %h",
							pressure_q24_8, e.press));
					if (pressure_valid !== e.ok)
						report($sformatf("pressure_valid %b, expected %b",
							pressure_valid, e.ok));
				end
			end
		end
	end

endmodule

[test/baro_temp_pressure_compensation_test.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_test
// drives raw readings through several calibration sets, with random gaps on
// both channels and one long output stall; the checker judges every result
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_test;
	import bptc_pkg::*;

	localparam int LIMIT = 600000;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [63:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [19:0]        raw_temperature;
	logic [19:0]        raw_pressure;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] temperature_centi;
	logic [31:0]        pressure_q24_8;
	logic               pressure_valid;
	int                 errors;
	int                 pending;
	int                 cycles;
	int                 beats_out;

	baro_temp_pressure_compensation uut (.*);
	baro_temp_pressure_compensation_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// output side: stretches of full flow, stretches of random stall, one long hold-off
	initial begin
		bit held;
		held = 0;
		beats_out = 0;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			if (!held && beats_out > 300) begin
				held = 1;
				out_ready <= 0;
				repeat (300) @(posedge clk);
			end
			if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				repeat ($urandom_range(5, 30)) begin
					out_ready <= (gap_len() == 0);
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk)
		if (out_valid && out_ready) beats_out++;

	task automatic write_reg(bptc_reg_t idx, logic [63:0] value);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 0;
	endtask

	task automatic set_cal(logic [63:0] tc, logic [63:0] lo, logic [63:0] hi,
			logic [63:0] last);
		write_reg(REG_TEMP_CAL, tc);
		write_reg(REG_PRESS_LOW, lo);
		write_reg(REG_PRESS_HIGH, hi);
		write_reg(REG_PRESS_LAST, last);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send(logic [19:0] t, logic [19:0] p);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid        <= 1;
		raw_temperature <= t;
		raw_pressure    <= p;
		@(posedge clk iff (in_valid && in_ready));
	endtask

	task automatic random_beats(int n);
		repeat (n) begin
			if ($urandom_range(0, 1))
				send($urandom_range(0, 20'hfffff), $urandom_range(0, 20'hfffff));
			else
				send($urandom_range(480000, 560000), $urandom_range(250000, 450000));
		end
		in_valid <= 0;
	endtask

	localparam logic [63:0] TYP_T  = {16'hfc18, 16'd26435, 16'd27504};
	localparam logic [63:0] TYP_LO = {16'd2855, 16'd3024, 16'hd643, 16'd36477};
	localparam logic [63:0] TYP_HI = {16'hc6f8, 16'd15500, 16'hfff9, 16'd140};

	initial begin
		arst_n = 0;
		cfg_write = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		raw_temperature = '0;
		raw_pressure = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset calibration: divisor zero
		send(20'd519888, 20'd415148);
		send(20'hfffff, 20'h00000);
		in_valid <= 0;
		drain();

		set_cal(TYP_T, TYP_LO, TYP_HI, 64'd6000);
		send(20'd519888, 20'd415148);
		send(20'h00000, 20'h00000);
		send(20'hfffff, 20'hfffff);
		send(20'h00000, 20'hfffff);
		send(20'hfffff, 20'h00000);
		send(20'h55555, 20'haaaaa);
		send(20'haaaaa, 20'h55555);
		send(20'd440064, 20'd1);
		in_valid <= 0;
		drain();

		// extreme coefficients, wrapping and saturation
		set_cal({16'h7fff, 16'h7fff, 16'hffff}, 64'h8000_8000_8000_ffff,
			64'h8000_8000_8000_8000, 64'h8000);
		send(20'h00000, 20'h00000);
		send(20'hfffff, 20'hfffff);
		send(20'h7ffff, 20'h80000);
		in_valid <= 0;
		drain();
		set_cal({16'h8000, 16'h8000, 16'h0000}, 64'h7fff_7fff_7fff_0001,
			64'h7fff_7fff_7fff_7fff, 64'h7fff);
		send(20'h00000, 20'h00000);
		send(20'hfffff, 20'hfffff);
		send(20'h12345, 20'hedcba);
		in_valid <= 0;
		drain();

		set_cal(TYP_T, TYP_LO, TYP_HI, 64'd6000);
		random_beats(500);
		drain();
		set_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		random_beats(250);
		drain();
		set_cal('1, '1, '1, '1);
		random_beats(200);
		drain();
		set_cal({16'h7fff, 16'h8000, 16'hffff}, 64'h8000_7fff_8000_ffff,
			64'h7fff_8000_7fff_8000, 64'h8000);
		random_beats(200);
		drain();
		set_cal('0, TYP_LO, TYP_HI, 64'd6000);
		random_beats(100);
		drain();
		set_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		random_beats(280);
		drain();

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/bptc_pkg.sv
rtl/bptc_div.sv
rtl/baro_temp_pressure_compensation.sv
test/baro_temp_pressure_compensation_checker.sv
test/baro_temp_pressure_compensation_test.sv
